// ----- rtl/core/rbs_pkg.sv -----
// Package for the record bubble sorter: word types, register codes, back-end states.
// Also holds the neighbour compare function used by the sorting engine.
// Has no dependencies; every other file but rbs_fifo imports it.
package rbs_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 8;
	localparam int CFG_DATA_W = 1;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the write port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DESCENDING    = 1'b0,
		REG_SWAP_ON_EQUAL = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic descending;
		logic swap_on_equal;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] sort_key;
		logic [TAG_W-1:0] record_tag;
		logic             final_record;
	} in_rec_t;

	typedef struct packed {
		logic [KEY_W-1:0] sorted_key;
		logic [TAG_W-1:0] sorted_tag;
		logic             end_of_set;
	} out_rec_t;

	// One stored record.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// Command passed from the front end to the back end.
	typedef struct packed {
		rec_t rec;
		logic final_record;
		logic keep;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS_FIRST,
		ST_PASS_RUN,
		ST_PASS_END,
		ST_EMIT_RD,
		ST_EMIT_WR
	} back_state_t;

	function automatic logic out_of_order(input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b, input cfg_t cfg);
		logic res;
		if (a == b) begin
			res = cfg.swap_on_equal;
		end else if (cfg.descending) begin
			res = (a < b);
		end else begin
			res = (a > b);
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/rbs_fifo.sv -----
// Small first-in first-out queue in flip-flops, used between the sorter stages.
// Depends on nothing but its parameters.
module rbs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ----- rtl/core/rbs_front.sv -----
// Front end of the record bubble sorter: accepts words and classifies them
// as stored, dropped (store full) or set-closing. Uses rbs_pkg.
module rbs_front import rbs_pkg::*; #(
	parameter int MAX_RECORDS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  in_rec_t rec_in,
	output logic    full,
	input  logic    cmd_full,
	output logic    cmd_push,
	output cmd_t    cmd
);

	localparam int CW = $clog2(MAX_RECORDS + 1);

	logic [CW-1:0] set_cnt_q;
	logic          accept;
	logic          drop;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign drop   = (set_cnt_q == CW'(MAX_RECORDS));

	// A dropped word still travels on when it closes the set.
	assign cmd_push         = accept && (!drop || rec_in.final_record);
	assign cmd.rec.key      = rec_in.sort_key;
	assign cmd.rec.tag      = rec_in.record_tag;
	assign cmd.final_record = rec_in.final_record;
	assign cmd.keep         = !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_cnt_q <= '0;
		end else if (accept) begin
			if (rec_in.final_record) begin
				set_cnt_q <= '0;
			end else if (!drop) begin
				set_cnt_q <= set_cnt_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/rbs_back.sv -----
// Back end of the record bubble sorter: loads records into the store, runs the
// bubble passes over one read and one write port and emits the sorted set. Uses rbs_pkg.
module rbs_back import rbs_pkg::*; #(
	parameter int MAX_RECORDS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     cmd_valid,
	input  cmd_t     cmd,
	output logic     cmd_pop,
	input  logic     out_full,
	output logic     out_push,
	output out_rec_t out_rec
);

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	rec_t        mem [MAX_RECORDS];
	rec_t        rdata_q;
	rec_t        carry_q;
	back_state_t state_q;
	back_state_t state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] emit_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	rec_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] n_new;
	logic          swap;
	logic          pass_last;
	logic          emit_last;

	assign n_new     = count_q + CW'(cmd.keep);
	assign swap      = out_of_order(carry_q.key, rdata_q.key, cfg);
	assign pass_last = ((j_q + 1'b1) == last_q);
	assign emit_last = ((CW'(emit_q) + 1'b1) == count_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (cmd_valid && cmd.final_record) begin
					state_d = (n_new > CW'(1)) ? ST_PASS_FIRST : ST_EMIT_RD;
				end
			end
			ST_PASS_FIRST: state_d = ST_PASS_RUN;
			ST_PASS_RUN: begin
				if (pass_last) begin
					state_d = ST_PASS_END;
				end
			end
			ST_PASS_END: begin
				state_d = (last_q == AW'(1)) ? ST_EMIT_RD : ST_PASS_FIRST;
			end
			ST_EMIT_RD: begin
				if (!out_full) begin
					state_d = ST_EMIT_WR;
				end
			end
			ST_EMIT_WR: state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	// The pass keeps the record that travels right in carry_q, so each
	// compare needs one read and one write.
	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = carry_q;
		mem_raddr = '0;
		out_push  = 1'b0;
		out_rec.sorted_key = rdata_q.key;
		out_rec.sorted_tag = rdata_q.tag;
		out_rec.end_of_set = emit_last;
		case (state_q)
			ST_LOAD: begin
				cmd_pop   = cmd_valid;
				mem_we    = cmd_valid && cmd.keep;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = cmd.rec;
			end
			ST_PASS_FIRST: mem_raddr = AW'(1);
			ST_PASS_RUN: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = swap ? rdata_q : carry_q;
				mem_raddr = pass_last ? '0 : j_q + AW'(2);
			end
			ST_PASS_END: begin
				mem_we    = 1'b1;
				mem_waddr = last_q;
				mem_wdata = carry_q;
			end
			ST_EMIT_RD: mem_raddr = emit_q;
			ST_EMIT_WR: out_push = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PASS_FIRST: carry_q <= rdata_q;
			ST_PASS_RUN: begin
				if (!swap) begin
					carry_q <= rdata_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			last_q  <= '0;
			j_q     <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (cmd_valid) begin
						count_q <= n_new;
						last_q  <= AW'(n_new - 1'b1);
						emit_q  <= '0;
					end
				end
				ST_PASS_FIRST: j_q <= '0;
				ST_PASS_RUN: j_q <= j_q + 1'b1;
				ST_PASS_END: last_q <= last_q - 1'b1;
				ST_EMIT_WR: begin
					if (emit_last) begin
						count_q <= '0;
					end else begin
						emit_q <= emit_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result word pushed into a full queue");

	a_pass_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS_RUN |-> j_q < last_q)
		else $error("compare position beyond end of pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECORDS))
		else $error("record count exceeds store depth");

	a_set_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_rec.end_of_set) |=> (state_q == ST_LOAD && count_q == '0))
		else $error("store not released after last word of set");

endmodule

// ----- rtl/core/record_bubble_sorter.sv -----
// Top level of the record bubble sorter: configuration registers, front end,
// command queue, back end and result queue. Uses rbs_pkg, rbs_fifo, rbs_front, rbs_back.
//
//   channel   direction  handshake          word
//   input     in         push / full        rec_in  (in_rec_t)
//   result    out        pop / empty        rec_out (out_rec_t)
//   config    in         wr_en (no wait)    wr_index, wr_data
//
// A set of n records is loaded into the store, sorted by bubble passes (one compare
// per cycle on the store's single read and write port) and then read out of the
// store. Reset clears the queues, counters and registers; the store needs no
// clearing. Either side may stall; the command queue lets input words of the
// next set arrive while the current set is sorted or drained.
module record_bubble_sorter import rbs_pkg::*; #(
	parameter int MAX_RECORDS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_rec_t               rec_in,
	output logic                  empty,
	input  logic                  pop,
	output out_rec_t              rec_out,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	cfg_t cfg_q;
	cmd_t front_cmd;
	logic front_push;
	logic cmd_full;
	logic [$bits(cmd_t)-1:0] cmd_word;
	logic cmd_empty;
	logic cmd_pop;
	logic out_full;
	logic out_push;
	out_rec_t back_rec;
	logic [$bits(out_rec_t)-1:0] out_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_DESCENDING:    cfg_q.descending <= wr_data[0];
				REG_SWAP_ON_EQUAL: cfg_q.swap_on_equal <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	rbs_front #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec_in   (rec_in),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (front_push),
		.cmd      (front_cmd)
	);

	rbs_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  (front_cmd),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_word),
		.empty  (cmd_empty)
	);

	rbs_back #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_t'(cmd_word)),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_rec   (back_rec)
	);

	rbs_fifo #(
		.WIDTH($bits(out_rec_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_rec),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_word),
		.empty  (empty)
	);

	assign rec_out = out_rec_t'(out_word);

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for record_bubble_sorter: feeds record sets, predicts the sorted words.
// Depends on rbs_pkg for the word types and register codes, and on the sorter RTL.
module testbench;
	import rbs_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 125;
	localparam int CALM_FROM = 100;

	localparam int KEYS_WIDE = 0;
	localparam int KEYS_TIED = 1;
	localparam int KEYS_CORNER = 2;

	// Mirrors the sorter: loads records, sorts each finished set and keeps the sorted words.
	class sorted_set_board;
		rec_t store [STORE_DEPTH];
		int unsigned loaded;
		logic descending;
		logic swap_ties;
		out_rec_t pending_sorted [$];
		int mismatches;

		function new();
			loaded = 0;
			descending = 1'b0;
			swap_ties = 1'b0;
			mismatches = 0;
		endfunction

		function void set_register(input reg_idx_t idx, input logic value);
			case (idx)
				REG_DESCENDING: begin
					descending = value;
				end
				REG_SWAP_ON_EQUAL: begin
					swap_ties = value;
				end
				default: begin
				end
			endcase
		endfunction

		function bit misplaced(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
			if (a == b)
				return swap_ties;
			return descending ? (a < b) : (a > b);
		endfunction

		function void load_record(input in_rec_t word);
			rec_t held;
			out_rec_t res;
			// Records beyond the store depth are dropped, but a final mark still counts.
			if (loaded < STORE_DEPTH) begin
				store[loaded].key = word.sort_key;
				store[loaded].tag = word.record_tag;
				loaded++;
			end
			if (!word.final_record)
				return;
			for (int pass = 0; pass + 1 < int'(loaded); pass++) begin
				for (int j = 0; j + 1 < int'(loaded) - pass; j++) begin
					if (misplaced(store[j].key, store[j + 1].key)) begin
						held = store[j];
						store[j] = store[j + 1];
						store[j + 1] = held;
					end
				end
			end
			for (int k = 0; k < int'(loaded); k++) begin
				res.sorted_key = store[k].key;
				res.sorted_tag = store[k].tag;
				res.end_of_set = (k + 1 == int'(loaded));
				pending_sorted.push_back(res);
			end
			loaded = 0;
		endfunction

		task report(input string what, input logic [KEY_W-1:0] got,
				input logic [KEY_W-1:0] want);
			$display("mismatch on %s: got %h, expected %h", what, got, want);
			mismatches++;
		endtask

		task check_emitted(input out_rec_t word);
			out_rec_t want;
			if (pending_sorted.size() == 0) begin
				report("result with none expected", word.sorted_key, '0);
				return;
			end
			want = pending_sorted.pop_front();
			if (word.sorted_key !== want.sorted_key)
				report("sorted_key", word.sorted_key, want.sorted_key);
			if (word.sorted_tag !== want.sorted_tag)
				report("sorted_tag", KEY_W'(word.sorted_tag), KEY_W'(want.sorted_tag));
			if (word.end_of_set !== want.end_of_set)
				report("end_of_set", KEY_W'(word.end_of_set), KEY_W'(want.end_of_set));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	in_rec_t rec_in;
	logic empty;
	logic pop;
	out_rec_t rec_out;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	sorted_set_board board;
	int push_gap_pct;
	int pop_gap_pct;
	bit calm;
	int cycles;

	record_bubble_sorter #(.MAX_RECORDS(STORE_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rec_in(rec_in),
		.empty(empty),
		.pop(pop),
		.rec_out(rec_out),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Both handshakes are sampled on the values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.load_record(rec_in);
			if (pop && !empty)
				board.check_emitted(rec_out);
		end
	end

	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < pop_gap_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic last);
		if (!calm && $urandom_range(0, 99) < push_gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push <= 1'b1;
		rec_in <= '{sort_key: key, record_tag: tag, final_record: last};
		do @(posedge clk); while (full);
	endtask

	// Waits until every sorted word has come back and the sorter has settled.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (board.pending_sorted.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		board.set_register(idx, value);
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input int mode);
		case (mode)
			KEYS_WIDE: begin
				return $urandom;
			end
			KEYS_TIED: begin
				return $urandom_range(0, 3);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return 32'h7fff_ffff;
					default: return 32'h8000_0000;
				endcase
			end
		endcase
	endfunction

	function automatic int pick_gap_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	initial begin
		int sent;
		int set_len;
		int sets;
		int key_mode;
		board = new();
		calm = 1'b0;
		push_gap_pct = 0;
		pop_gap_pct = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		rec_in <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_DESCENDING, 1'b0);
		write_reg(REG_SWAP_ON_EQUAL, 1'b0);
		send_record('1, 8'hff, 1'b1);
		drain();

		// Equal keys keep their load order unless ties are swapped.
		send_record(32'd5, 8'h01, 1'b0);
		send_record(32'd0, 8'h00, 1'b0);
		send_record(32'd5, 8'h02, 1'b1);
		drain();
		write_reg(REG_SWAP_ON_EQUAL, 1'b1);
		send_record(32'd7, 8'h10, 1'b0);
		send_record(32'd7, 8'h20, 1'b0);
		send_record('1, 8'h30, 1'b1);
		drain();
		write_reg(REG_DESCENDING, 1'b1);
		push_gap_pct = 40;
		pop_gap_pct = 40;
		send_record(32'd0, 8'h00, 1'b0);
		send_record('1, 8'h80, 1'b0);
		send_record(32'h8000_0000, 8'h7f, 1'b1);
		drain();

		// The two records past the store depth are dropped; the last one's final mark still counts.
		write_reg(REG_SWAP_ON_EQUAL, 1'b0);
		for (int i = 0; i < STORE_DEPTH + 2; i++)
			send_record(pick_key(KEYS_WIDE), i[TAG_W-1:0], i == STORE_DEPTH + 1);
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= CALM_FROM) begin
				calm = 1'b1;
			end else begin
				push_gap_pct = pick_gap_pct();
				pop_gap_pct = pick_gap_pct();
			end
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_DESCENDING, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_SWAP_ON_EQUAL, 1'($urandom_range(0, 1)));
			sets = $urandom_range(1, 3);
			for (int s = 0; s < sets; s++) begin
				case ($urandom_range(0, 19)) inside
					[0:11]: set_len = $urandom_range(1, 6);
					[12:17]: set_len = $urandom_range(7, STORE_DEPTH);
					default: set_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
				endcase
				key_mode = $urandom_range(KEYS_WIDE, KEYS_CORNER);
				for (int i = 0; i < set_len; i++) begin
					send_record(pick_key(key_mode), TAG_W'($urandom_range(0, 255)),
						i == set_len - 1);
					sent++;
				end
			end
			drain();
		end

		calm = 1'b1;
		repeat (20) @(posedge clk);
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/rbs_pkg.sv
rtl/core/rbs_fifo.sv
rtl/core/rbs_front.sv
rtl/core/rbs_back.sv
rtl/core/record_bubble_sorter.sv
bench/testbench.sv
